// ----- hw/rtl/sgcr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph column renderer package
// Shared types, constants, the 5x7 column font and the row expansion helper.
// ----------------------------------------------------------------------------
package sgcr_pkg;

	localparam int MAX_SCALE   = 4;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int CELL_COLS   = 6;
	localparam int MASK_W      = GLYPH_ROWS * MAX_SCALE;
	localparam int CASE_OFFSET = 32;

	localparam logic [4:0] GLYPH_BLANK = 5'd26;
	localparam logic [4:0] GLYPH_BANG  = 5'd27;

	localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TEXT_COLOR     = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic [5:0] char_position;
		logic [6:0] line_length;
		logic [7:0] line_top;
		logic [2:0] scale;
	} sgcr_in_t;

	typedef struct packed {
		logic [10:0]       column_x;
		logic [7:0]        row_top;
		logic [MASK_W-1:0] column_mask;
		logic              last_column;
	} sgcr_out_t;

	typedef struct packed {
		logic [10:0]       base_x;
		logic [7:0]        top;
		logic [MASK_W-1:0] row_mask;
		logic [4:0]        glyph;
		logic [2:0]        scale;
	} sgcr_job_t;

	typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

	function automatic logic [4:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c inside {[8'h61:8'h7A]})
			c = c - 8'(CASE_OFFSET);
		if (c inside {[8'h41:8'h5A]})
			return 5'(c - 8'h41);
		if (c == 8'h21)
			return GLYPH_BANG;
		return GLYPH_BLANK;
	endfunction

	function automatic glyph_t glyph_rom(input logic [4:0] idx);
		glyph_t g;
		case (idx)
			5'd0:    g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
			5'd1:    g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
			5'd2:    g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
			5'd3:    g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
			5'd4:    g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
			5'd5:    g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
			5'd6:    g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
			5'd7:    g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			5'd8:    g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
			5'd9:    g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
			5'd10:   g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
			5'd11:   g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
			5'd12:   g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
			5'd13:   g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
			5'd14:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
			5'd15:   g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
			5'd16:   g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
			5'd17:   g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
			5'd18:   g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
			5'd19:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			5'd20:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
			5'd21:   g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
			5'd22:   g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
			5'd23:   g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
			5'd24:   g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
			5'd25:   g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
			5'd27:   g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
			default: g = '0;
		endcase
		return g;
	endfunction

	// Each font row is repeated scale times down the column.
	function automatic logic [MASK_W-1:0] expand_rows(input logic [GLYPH_ROWS-1:0] bits,
			input logic [2:0] scale);
		logic [MASK_W-1:0] w;
		w = '0;
		for (int s = 1; s <= MAX_SCALE; s++) begin
			if (scale == 3'(s)) begin
				for (int r = 0; r < GLYPH_ROWS; r++) begin
					for (int k = 0; k < s; k++) begin
						w[r*s+k] = bits[r];
					end
				end
			end
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sgcr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph column renderer front end
// Accepts characters, folds the code to a glyph, clamps the scale, computes
// the cell offsets and the vertical clip mask, and queues a job.
// ----------------------------------------------------------------------------
module sgcr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sgcr_pkg::sgcr_in_t in_data,
	input  wire logic [7:0]         display_width,
	input  wire logic [7:0]         display_height,
	output logic                    push,
	output sgcr_pkg::sgcr_job_t     push_job,
	input  wire logic               queue_full
);
	import sgcr_pkg::*;

	logic              valid_s1;
	logic [4:0]        glyph_s1;
	logic [2:0]        scale_s1;
	logic [7:0]        top_s1;
	logic [MASK_W-1:0] row_mask_s1;
	logic [11:0]       line_px_s1;
	logic [10:0]       pos_px_s1;

	logic [2:0]        scale_c;
	logic [4:0]        cell_c;
	logic [MASK_W-1:0] row_mask_c;
	logic signed [12:0] diff_c;
	logic [7:0]        start_c;

	assign in_stall = valid_s1 && queue_full;

	always_comb begin
		if (in_data.scale == 3'd0)
			scale_c = 3'd1;
		else if (in_data.scale > 3'(MAX_SCALE))
			scale_c = 3'(MAX_SCALE);
		else
			scale_c = in_data.scale;
		cell_c = 5'(scale_c) * 5'(CELL_COLS);
		for (int j = 0; j < MASK_W; j++) begin
			row_mask_c[j] = ({1'b0, in_data.line_top} + 9'(j)) < {1'b0, display_height};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			glyph_s1    <= glyph_index(in_data.char_code);
			scale_s1    <= scale_c;
			top_s1      <= in_data.line_top;
			row_mask_s1 <= row_mask_c;
			line_px_s1  <= 12'(in_data.line_length) * 12'(cell_c);
			pos_px_s1   <= 11'(in_data.char_position) * 11'(cell_c);
		end
	end

	always_comb begin
		diff_c  = $signed({5'd0, display_width}) - $signed({1'b0, line_px_s1});
		start_c = (diff_c > 13'sd0) ? diff_c[8:1] : 8'd0;
		push_job.base_x   = {3'b000, start_c} + pos_px_s1;
		push_job.top      = top_s1;
		push_job.row_mask = row_mask_s1;
		push_job.glyph    = glyph_s1;
		push_job.scale    = scale_s1;
	end

	assign push = valid_s1 && !queue_full;

endmodule
`default_nettype wire

// ----- hw/rtl/sgcr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph column renderer job queue
// Small register FIFO that decouples the front end from the column sequencer.
// ----------------------------------------------------------------------------
module sgcr_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sgcr_pkg::sgcr_job_t push_job,
	output logic                     full,
	input  wire logic                pop,
	output logic                     head_valid,
	output sgcr_pkg::sgcr_job_t      head_job
);
	import sgcr_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sgcr_job_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone push");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/sgcr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph column renderer column sequencer
// Walks the pixel columns of the job at the queue head, one per cycle while the
// output is not stalled, and drives the registered result channel.
// ----------------------------------------------------------------------------
module sgcr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire sgcr_pkg::sgcr_job_t head_job,
	output logic                     pop,
	input  wire logic [7:0]          display_width,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sgcr_pkg::sgcr_out_t      out_data
);
	import sgcr_pkg::*;

	logic              out_valid_q;
	sgcr_out_t         out_data_q;
	logic [2:0]        col_q;
	logic [2:0]        sx_q;
	logic [4:0]        off_q;

	logic              load;
	logic              sx_last;
	logic              col_last;
	glyph_t            glyph;
	logic [MASK_W-1:0] wide;
	logic [10:0]       x;

	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign sx_last  = sx_q == head_job.scale - 3'd1;
	assign col_last = col_q == 3'(GLYPH_COLS - 1);
	assign pop      = load && sx_last && col_last;

	always_comb begin
		glyph = glyph_rom(head_job.glyph);
		wide  = expand_rows(glyph[col_q], head_job.scale) & head_job.row_mask;
		x     = head_job.base_x + 11'(off_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			sx_q        <= '0;
			off_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load) begin
				if (sx_last && col_last) begin
					col_q <= '0;
					sx_q  <= '0;
					off_q <= '0;
				end else begin
					off_q <= off_q + 1'b1;
					if (sx_last) begin
						sx_q  <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.column_x    <= x;
			out_data_q.row_top     <= head_job.top;
			out_data_q.column_mask <= (x < {3'b000, display_width}) ? wide : '0;
			out_data_q.last_column <= sx_last && col_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= 3'(GLYPH_COLS - 1))
		else $error("column counter out of range");
	a_sx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> sx_q < head_job.scale)
		else $error("sub-column counter reached the scale");
	a_off_start: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == 3'd0 && sx_q == 3'd0) |-> off_q == 5'd0)
		else $error("column offset not cleared at character start");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/scaled_glyph_column_renderer_top.sv -----
`default_nettype none
// The first column of a character passes the front-end register, the job queue and the output register.
// Throughput: one column per cycle while the output is not stalled, 5 * scale columns per character (5 to 20).
// The column sequencer, which emits one pixel column per cycle unless the output stalls, sets that rate.
// The front end and job queue accept new characters while the sequencer works.
// Reset clears the queue and all valid flags; width and height return to 128.
// ----------------------------------------------------------------------------
// Scaled glyph column renderer
// Renders centered, scaled 5x7 characters as a stream of clipped pixel columns.
// ----------------------------------------------------------------------------
module scaled_glyph_column_renderer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sgcr_pkg::sgcr_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sgcr_pkg::sgcr_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import sgcr_pkg::*;

	logic [7:0] display_width_q;
	logic [7:0] display_height_q;
	logic       push;
	sgcr_job_t  push_job;
	logic       queue_full;
	logic       pop;
	logic       head_valid;
	sgcr_job_t  head_job;

	assign cfg_ready = 1'b1;

	// The text color register is accepted but feeds no result field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_width_q  <= 8'd128;
			display_height_q <= 8'd128;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DISPLAY_WIDTH:  display_width_q  <= cfg_data[7:0];
				CFG_DISPLAY_HEIGHT: display_height_q <= cfg_data[7:0];
				CFG_TEXT_COLOR:     ;
				default:            ;
			endcase
		end
	end

	sgcr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.display_width  (display_width_q),
		.display_height (display_height_q),
		.push           (push),
		.push_job       (push_job),
		.queue_full     (queue_full)
	);

	sgcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sgcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.display_width (display_width_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule
`default_nettype wire
